// File: hw/rtl/krt_pkg.sv
// Shared types, constants and helpers for the keyed record table.
package krt_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int BRAND_W  = 64;
   localparam int PLATE_W  = 32;
   localparam int REF_W    = 16;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int LIMIT_W  = 5;

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 24;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

   localparam int LIMIT_RESET_INT = (16 > CAPACITY) ? CAPACITY : 16;
   localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(LIMIT_RESET_INT);

   typedef struct packed {
      logic [BRAND_W-1:0] brand;
      logic [PLATE_W-1:0] plate;
      logic [REF_W-1:0]   ref_val;
   } record_type;

   typedef struct packed {
      logic capture;
      logic ins;
      logic rd_search;
      logic take_hit;
      logic dec_count;
      logic rd_shift;
      logic wr_shift;
      logic idx_inc;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic idx_end;
      logic hit;
      logic is_remove;
   } stat_type;

   // Clear every byte from the first zero byte upward.
   function automatic logic [BRAND_W-1:0] brand_norm(input logic [BRAND_W-1:0] b);
      logic [BRAND_W-1:0] res;
      logic               stop;
      res  = '0;
      stop = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (b[8*i +: 8] == 8'd0) begin
            stop = 1'b1;
         end
         if (!stop) begin
            res[8*i +: 8] = b[8*i +: 8];
         end
      end
      return res;
   endfunction

   function automatic logic [CNT_W-1:0] clamp_limit(input logic [LIMIT_W-1:0] v);
      logic [CNT_W-1:0] res;
      if (32'(v) > 32'(CAPACITY)) begin
         res = CNT_W'(CAPACITY);
      end else begin
         res = CNT_W'(v);
      end
      return res;
   endfunction

endpackage

// File: hw/rtl/krt_ctrl.sv
// Sequencing state machine for insert, search and shift-down of the record table.
module krt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [1:0]        req_kind,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  krt_pkg::stat_type stat,
   output krt_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_INSERT   = 3'd1;
   localparam logic [2:0] S_SEARCH   = 3'd2;
   localparam logic [2:0] S_CHECK    = 3'd3;
   localparam logic [2:0] S_SHIFT_RD = 3'd4;
   localparam logic [2:0] S_SHIFT_WR = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_tready   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               unique case (req_kind) inside
                  krt_pkg::KIND_INSERT: state_in = S_INSERT;
                  krt_pkg::KIND_QUERY, krt_pkg::KIND_REMOVE: state_in = S_SEARCH;
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_INSERT: begin
            cmd.ins  = 1'b1;
            state_in = S_FINISH;
         end
         S_SEARCH: begin
            if (stat.idx_end) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_search = 1'b1;
               state_in      = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.hit) begin
               cmd.take_hit = 1'b1;
               if (stat.is_remove) begin
                  cmd.dec_count = 1'b1;
                  state_in      = S_SHIFT_RD;
               end else begin
                  state_in = S_FINISH;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SEARCH;
            end
         end
         S_SHIFT_RD: begin
            if (stat.idx_end) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_shift = 1'b1;
               state_in     = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: hw/rtl/krt_dpath.sv
// Record memory, count, limit, search index and result registers of the record table.
module krt_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  krt_pkg::cmd_type                    cmd,
   output krt_pkg::stat_type                   stat,
   input  logic [krt_pkg::KIND_W-1:0]          req_kind,
   input  logic [krt_pkg::REQ_DATA_W-1:0]      req_data,
   input  logic                                csr_we,
   input  logic [krt_pkg::LIMIT_W-1:0]         csr_value,
   output logic [krt_pkg::STATUS_W-1:0]        rsp_status,
   output logic [krt_pkg::REF_W-1:0]           rsp_ref,
   output logic [krt_pkg::COUNT_W-1:0]         rsp_count
);

   krt_pkg::record_type mem [krt_pkg::CAPACITY];

   logic [krt_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [krt_pkg::BRAND_W-1:0]  brand_ff, brand_in;
   logic [krt_pkg::PLATE_W-1:0]  plate_ff, plate_in;
   logic [krt_pkg::REF_W-1:0]    ref_ff, ref_in;
   logic [krt_pkg::CNT_W-1:0]    idx_ff, idx_in;
   logic [krt_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [krt_pkg::CNT_W-1:0]    limit_ff, limit_in;
   logic [krt_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [krt_pkg::REF_W-1:0]    fref_ff, fref_in;
   logic [krt_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [krt_pkg::REF_W-1:0]    rsp_ref_ff, rsp_ref_in;
   logic [krt_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   krt_pkg::record_type          rd_ff;

   logic                         room;
   logic                         wr_en;
   logic [krt_pkg::IDX_W-1:0]    wr_addr;
   krt_pkg::record_type          wr_data;
   logic                         rd_en;
   logic [krt_pkg::IDX_W-1:0]    rd_addr;
   logic [krt_pkg::CNT_W-1:0]    idx_next;

   assign room     = (count_ff < limit_ff);
   assign idx_next = idx_ff + krt_pkg::CNT_W'(1);

   always_comb begin
      kind_in       = kind_ff;
      brand_in      = brand_ff;
      plate_in      = plate_ff;
      ref_in        = ref_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      limit_in      = limit_ff;
      status_in     = status_ff;
      fref_in       = fref_ff;
      rsp_status_in = rsp_status_ff;
      rsp_ref_in    = rsp_ref_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[krt_pkg::IDX_W-1:0];
      wr_data       = rd_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[krt_pkg::IDX_W-1:0];

      if (csr_we) begin
         limit_in = krt_pkg::clamp_limit(csr_value);
      end

      if (cmd.capture) begin
         kind_in   = req_kind;
         brand_in  = krt_pkg::brand_norm(req_data[63:0]);
         plate_in  = req_data[95:64];
         ref_in    = req_data[111:96];
         idx_in    = '0;
         status_in = krt_pkg::ST_NOT_FOUND;
         fref_in   = '0;
      end

      if (cmd.ins) begin
         if (room) begin
            wr_en     = 1'b1;
            wr_addr   = count_ff[krt_pkg::IDX_W-1:0];
            wr_data   = '{brand: brand_ff, plate: plate_ff, ref_val: ref_ff};
            count_in  = count_ff + krt_pkg::CNT_W'(1);
            status_in = krt_pkg::ST_OK;
         end else begin
            status_in = krt_pkg::ST_FULL;
         end
      end

      if (cmd.rd_search) begin
         rd_en   = 1'b1;
         rd_addr = idx_ff[krt_pkg::IDX_W-1:0];
      end

      if (cmd.rd_shift) begin
         rd_en   = 1'b1;
         rd_addr = idx_next[krt_pkg::IDX_W-1:0];
      end

      if (cmd.take_hit) begin
         status_in = krt_pkg::ST_OK;
         fref_in   = rd_ff.ref_val;
      end

      if (cmd.dec_count) begin
         count_in = count_ff - krt_pkg::CNT_W'(1);
      end

      if (cmd.wr_shift) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff[krt_pkg::IDX_W-1:0];
         wr_data = rd_ff;
      end

      if (cmd.idx_inc) begin
         idx_in = idx_next;
      end

      if (cmd.load_rsp) begin
         rsp_status_in = status_ff;
         rsp_ref_in    = fref_ff;
         rsp_count_in  = krt_pkg::COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         limit_ff <= krt_pkg::LIMIT_RESET;
      end else begin
         count_ff <= count_in;
         limit_ff <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      brand_ff      <= brand_in;
      plate_ff      <= plate_in;
      ref_ff        <= ref_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      fref_ff       <= fref_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ref_ff    <= rsp_ref_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign stat.idx_end   = (idx_ff >= count_ff);
   assign stat.hit       = (rd_ff.brand == brand_ff) && (rd_ff.plate == plate_ff);
   assign stat.is_remove = (kind_ff == krt_pkg::KIND_REMOVE);

   assign rsp_status = rsp_status_ff;
   assign rsp_ref    = rsp_ref_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

// File: hw/rtl/keyed_record_table_unit.sv
// Top level of the keyed record table: controller, datapath and stream ports.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tuser kind, tdata brand/plate/ref
//   rsp      out        rsp_tvalid/rsp_tready  tuser status, tdata found_ref/count
//   csr      in         csr_valid/csr_ready    max_entries (5 bits)
//
// Insert goes through the insert step to the finish step. Query reads and compares one
// record at a time (search, then check) until a hit or the end of the table. Remove: a
// query hit, then each later record is read and written one slot down (shift read, shift write).
// Synchronous reset clears the count and sets the limit to min(16, CAPACITY).
// A new transfer is taken while a result waits on rsp; the finish step holds until
// the output register frees up. csr is always ready.
module keyed_record_table_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [krt_pkg::KIND_W-1:0]            req_tuser,  // [1:0] kind
   // [63:0] key_brand, [95:64] key_plate, [111:96] entry_ref
   input  logic [krt_pkg::REQ_DATA_W-1:0]        req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [krt_pkg::STATUS_W-1:0]          rsp_tuser,  // [1:0] status
   // [15:0] found_ref, [20:16] count, [23:21] zero
   output logic [krt_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [krt_pkg::LIMIT_W-1:0]           csr_data    // [4:0] max_entries
);

   krt_pkg::cmd_type             cmd;
   krt_pkg::stat_type            stat;
   logic [krt_pkg::REF_W-1:0]    rsp_ref;
   logic [krt_pkg::COUNT_W-1:0]  rsp_count;

   assign csr_ready = 1'b1;

   krt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   krt_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_kind   (req_tuser),
      .req_data   (req_tdata),
      .csr_we     (csr_valid),
      .csr_value  (csr_data),
      .rsp_status (rsp_tuser),
      .rsp_ref    (rsp_ref),
      .rsp_count  (rsp_count)
   );

   assign rsp_tdata = {3'b000, rsp_count, rsp_ref};

endmodule

// File: tb/sv/keyed_record_table_unit_test.sv
// Self-checking stream testbench for the keyed record table unit.
module keyed_record_table_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [krt_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int HOLD_AT_RESULT = 300;
   localparam int HOLD_CYCLES    = 600;
   localparam int STALL_LIMIT    = 2500;
   localparam int PHASE_ITEMS    = 120;
   localparam int NUM_PHASES     = 10;

   typedef struct packed {
      logic [krt_pkg::KIND_W-1:0]  kind;
      logic [krt_pkg::BRAND_W-1:0] brand;
      logic [krt_pkg::PLATE_W-1:0] plate;
      logic [krt_pkg::REF_W-1:0]   entry_ref;
   } req_item_type;

   typedef struct packed {
      logic [krt_pkg::STATUS_W-1:0] status;
      logic [krt_pkg::REF_W-1:0]    found_ref;
      logic [krt_pkg::COUNT_W-1:0]  count;
   } rsp_item_type;

   typedef struct packed {
      bit           pinned;
      rsp_item_type want;
   } typed_rsp_type;

   typedef struct {
      req_item_type item;
      bit           pinned;
      rsp_item_type want;
   } dir_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [krt_pkg::KIND_W-1:0]     req_tuser = '0;
   logic [krt_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [krt_pkg::STATUS_W-1:0]   rsp_tuser;
   logic [krt_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [krt_pkg::LIMIT_W-1:0]    csr_data = '0;

   // table state tracked alongside the block
   logic [krt_pkg::BRAND_W-1:0] tbl_brand [krt_pkg::CAPACITY];
   logic [krt_pkg::PLATE_W-1:0] tbl_plate [krt_pkg::CAPACITY];
   logic [krt_pkg::REF_W-1:0]   tbl_ref   [krt_pkg::CAPACITY];
   int                          tbl_count = 0;
   int                          tbl_limit = krt_pkg::LIMIT_RESET_INT;

   rsp_item_type                rsp_due_q [$];
   typed_rsp_type               typed_q   [$];
   dir_row_type                 dir_rows  [$];
   logic [krt_pkg::BRAND_W-1:0] brand_pool [4];
   logic [krt_pkg::PLATE_W-1:0] plate_pool [4];
   int                          reqs_sent = 0;
   int                          results_seen = 0;
   int                          error_count = 0;
   int                          src_burst = 0;

   keyed_record_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [krt_pkg::BRAND_W-1:0] strip_brand(
         logic [krt_pkg::BRAND_W-1:0] raw);
      int len;
      len = 8;
      for (int k = 7; k >= 0; k--) begin
         if (raw[8*k +: 8] == 8'h00) begin
            len = k;
         end
      end
      if (len == 0) begin
         return '0;
      end
      return raw & ({krt_pkg::BRAND_W{1'b1}} >> (krt_pkg::BRAND_W - 8 * len));
   endfunction

   function automatic int clip_limit(logic [krt_pkg::LIMIT_W-1:0] raw);
      return (int'(raw) > krt_pkg::CAPACITY) ? krt_pkg::CAPACITY : int'(raw);
   endfunction

   function automatic rsp_item_type apply_table_op(req_item_type it);
      rsp_item_type                res;
      logic [krt_pkg::BRAND_W-1:0] key;
      int                          hit;
      key           = strip_brand(it.brand);
      res.status    = krt_pkg::ST_NOT_FOUND;
      res.found_ref = '0;
      case (it.kind) inside
         krt_pkg::KIND_INSERT: begin
            if (tbl_count < tbl_limit) begin
               tbl_brand[tbl_count] = key;
               tbl_plate[tbl_count] = it.plate;
               tbl_ref[tbl_count]   = it.entry_ref;
               tbl_count++;
               res.status = krt_pkg::ST_OK;
            end else begin
               res.status = krt_pkg::ST_FULL;
            end
         end
         krt_pkg::KIND_QUERY, krt_pkg::KIND_REMOVE: begin
            hit = -1;
            for (int i = 0; i < tbl_count; i++) begin
               if (hit < 0 && tbl_brand[i] == key && tbl_plate[i] == it.plate) begin
                  hit = i;
               end
            end
            if (hit >= 0) begin
               res.status    = krt_pkg::ST_OK;
               res.found_ref = tbl_ref[hit];
               if (it.kind == krt_pkg::KIND_REMOVE) begin
                  for (int j = hit; j < tbl_count - 1; j++) begin
                     tbl_brand[j] = tbl_brand[j+1];
                     tbl_plate[j] = tbl_plate[j+1];
                     tbl_ref[j]   = tbl_ref[j+1];
                  end
                  tbl_count--;
               end
            end
         end
         default: ;
      endcase
      res.count = krt_pkg::COUNT_W'(tbl_count);
      return res;
   endfunction

   function automatic int next_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 31) == 0) begin
         burst = $urandom_range(20, 80);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   // refill the bytes past the string end with junk
   function automatic logic [krt_pkg::BRAND_W-1:0] dress_brand(
         logic [krt_pkg::BRAND_W-1:0] base);
      logic [krt_pkg::BRAND_W-1:0] res;
      int                          len;
      res = base;
      len = 8;
      for (int k = 7; k >= 0; k--) begin
         if (base[8*k +: 8] == 8'h00) begin
            len = k;
         end
      end
      for (int k = len + 1; k < 8; k++) begin
         res[8*k +: 8] = 8'($urandom);
      end
      return res;
   endfunction

   function automatic req_item_type make_item(int ins_pct);
      req_item_type it;
      int           pick;
      pick         = $urandom_range(0, 99);
      it.brand     = dress_brand(brand_pool[$urandom_range(0, 3)]);
      it.plate     = plate_pool[$urandom_range(0, 3)];
      it.entry_ref = 16'($urandom);
      if (pick < 5) begin
         it.kind  = 2'($urandom_range(0, 3));
         it.brand = {$urandom, $urandom};
         it.plate = $urandom;
      end else if (pick < 9) begin
         it.kind = KIND_UNUSED;
      end else if ($urandom_range(0, 99) < ins_pct) begin
         it.kind = krt_pkg::KIND_INSERT;
      end else begin
         it.kind = $urandom_range(0, 1) ? krt_pkg::KIND_QUERY : krt_pkg::KIND_REMOVE;
      end
      return it;
   endfunction

   task automatic add_row(logic [krt_pkg::KIND_W-1:0] kind,
                          logic [krt_pkg::BRAND_W-1:0] brand,
                          logic [krt_pkg::PLATE_W-1:0] plate,
                          logic [krt_pkg::REF_W-1:0] eref, bit pinned,
                          logic [krt_pkg::STATUS_W-1:0] st,
                          logic [krt_pkg::REF_W-1:0] fref,
                          logic [krt_pkg::COUNT_W-1:0] cnt);
      dir_row_type row;
      row.item   = '{kind: kind, brand: brand, plate: plate, entry_ref: eref};
      row.pinned = pinned;
      row.want   = '{status: st, found_ref: fref, count: cnt};
      dir_rows.push_back(row);
   endtask

   task automatic send_req(req_item_type it);
      int gap;
      gap = next_gap(src_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {it.entry_ref, it.plate, it.brand};
      do @(posedge clock); while (!req_tready);
      reqs_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (results_seen < reqs_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(logic [krt_pkg::LIMIT_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic check_rsp(rsp_item_type want, rsp_item_type got);
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         error_count++;
      end
      if (got.found_ref !== want.found_ref) begin
         $error("found_ref: expected %h, got %h", want.found_ref, got.found_ref);
         error_count++;
      end
      if (got.count !== want.count) begin
         $error("count: expected %0d, got %0d", want.count, got.count);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_item_type  got;
      rsp_item_type  want;
      typed_rsp_type typed;
      req_item_type  it;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got = '{status: rsp_tuser, found_ref: rsp_tdata[15:0], count: rsp_tdata[20:16]};
            if (rsp_due_q.size() == 0) begin
               $error("rsp transfer with nothing pending: status %0d", got.status);
               error_count++;
            end else begin
               check_rsp(rsp_due_q.pop_front(), got);
            end
         end
         if (req_tvalid && req_tready) begin
            it   = '{kind: req_tuser, brand: req_tdata[63:0], plate: req_tdata[95:64],
                     entry_ref: req_tdata[111:96]};
            want = apply_table_op(it);
            if (typed_q.size() > 0) begin
               typed = typed_q.pop_front();
               if (typed.pinned) begin
                  want = typed.want;
               end
            end
            rsp_due_q.push_back(want);
         end
         if (csr_valid && csr_ready) begin
            tbl_limit = clip_limit(csr_data);
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : sink
      int gap;
      int burst;
      int taken;
      burst = 0;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (taken == HOLD_AT_RESULT) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = next_gap(burst);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   initial begin : stimulus
      logic [krt_pkg::BRAND_W-1:0] b_ones;
      logic [krt_pkg::BRAND_W-1:0] b_ab;
      logic [krt_pkg::BRAND_W-1:0] b_seq;
      logic [krt_pkg::LIMIT_W-1:0] limits [NUM_PHASES];
      int                          len;
      b_ones = '1;
      b_ab   = 64'h1234_5678_9A00_4241;
      b_seq  = 64'h0102_0304_0506_0708;
      limits = '{5'd31, 5'd2, 5'd0, 5'd16, 5'd1, 5'd9, 5'($urandom), 5'd16, 5'd4,
                 5'($urandom)};
      for (int p = 0; p < 4; p++) begin
         len           = $urandom_range(0, 8);
         brand_pool[p] = '0;
         for (int k = 0; k < len; k++) begin
            brand_pool[p][8*k +: 8] = 8'($urandom_range(1, 255));
         end
         plate_pool[p] = $urandom;
      end

      add_row(krt_pkg::KIND_QUERY, b_ab, 32'd7, 16'h0000,
              1, krt_pkg::ST_NOT_FOUND, 16'h0000, 5'd0);
      add_row(krt_pkg::KIND_REMOVE, b_ones, '1, 16'h0000,
              1, krt_pkg::ST_NOT_FOUND, 16'h0000, 5'd0);
      add_row(KIND_UNUSED, b_ones, '1, 16'hFFFF,
              1, krt_pkg::ST_NOT_FOUND, 16'h0000, 5'd0);
      add_row(krt_pkg::KIND_INSERT, b_ones, '1, 16'hFFFF,
              1, krt_pkg::ST_OK, 16'h0000, 5'd1);
      add_row(krt_pkg::KIND_INSERT, '0, '0, 16'h0000,
              1, krt_pkg::ST_OK, 16'h0000, 5'd2);
      add_row(krt_pkg::KIND_INSERT, b_ab, 32'd7, 16'h1234,
              1, krt_pkg::ST_OK, 16'h0000, 5'd3);
      add_row(krt_pkg::KIND_QUERY, 64'h4241, 32'd7, 16'h0000,
              1, krt_pkg::ST_OK, 16'h1234, 5'd3);
      add_row(krt_pkg::KIND_QUERY, b_ones, '1, 16'h0000,
              1, krt_pkg::ST_OK, 16'hFFFF, 5'd3);
      add_row(krt_pkg::KIND_QUERY, 64'hFFFF_FFFF_FFFF_FF00, '0, 16'h0000,
              1, krt_pkg::ST_OK, 16'h0000, 5'd3);
      add_row(krt_pkg::KIND_QUERY, 64'h4241, 32'd8, 16'h0000,
              1, krt_pkg::ST_NOT_FOUND, 16'h0000, 5'd3);
      add_row(krt_pkg::KIND_INSERT, 64'hAAAA_0000_0000_4241, 32'd7, 16'h5678,
              1, krt_pkg::ST_OK, 16'h0000, 5'd4);
      add_row(krt_pkg::KIND_QUERY, b_ab, 32'd7, 16'h0000,
              1, krt_pkg::ST_OK, 16'h1234, 5'd4);
      add_row(krt_pkg::KIND_REMOVE, 64'h4241, 32'd7, 16'h0000,
              1, krt_pkg::ST_OK, 16'h1234, 5'd3);
      add_row(krt_pkg::KIND_QUERY, b_ab, 32'd7, 16'h0000,
              1, krt_pkg::ST_OK, 16'h5678, 5'd3);
      add_row(KIND_UNUSED, '0, '0, 16'h0000,
              1, krt_pkg::ST_NOT_FOUND, 16'h0000, 5'd3);
      add_row(krt_pkg::KIND_QUERY, b_ones, '1, 16'hFFFF,
              1, krt_pkg::ST_OK, 16'hFFFF, 5'd3);
      add_row(krt_pkg::KIND_REMOVE, b_ones, '1, 16'h0000,
              1, krt_pkg::ST_OK, 16'hFFFF, 5'd2);
      add_row(krt_pkg::KIND_REMOVE, b_ones, '1, 16'h0000,
              1, krt_pkg::ST_NOT_FOUND, 16'h0000, 5'd2);
      add_row(krt_pkg::KIND_INSERT, b_seq, 32'h8000_0001, 16'h00FF,
              0, krt_pkg::ST_OK, '0, '0);
      add_row(krt_pkg::KIND_QUERY, b_seq, 32'h8000_0001, 16'h0000,
              0, krt_pkg::ST_OK, '0, '0);
      add_row(krt_pkg::KIND_REMOVE, '0, '0, 16'h0000,
              0, krt_pkg::ST_OK, '0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         typed_q.push_back('{pinned: dir_rows[i].pinned, want: dir_rows[i].want});
         send_req(dir_rows[i].item);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_limit(limits[ph]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_req(make_item((ph % 2 == 0) ? 60 : 25));
         end
      end

      drain_results();
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
